FILE: sv/timed_event_queue_core_defines.svh
// Assertion macros for the timed event queue RTL, used by the datapath.
// Each macro expects clk and arst_n to be visible in the including module.
`ifndef TIMED_EVENT_QUEUE_CORE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TEQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define TEQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/teq_pkg.sv
// Shared types and constants for the timed event queue.
// Used by the controller, the datapath and the top level.
package teq_pkg;

	// Default sizes
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	// Field widths fixed by the item format
	localparam int ELAPSED_W = 16;
	localparam int RATE_W    = 16;
	localparam int FRAME_W   = 32;
	localparam int WHOLE_W   = 16;
	localparam int PROD_W    = ELAPSED_W + RATE_W;
	localparam int INC_SHIFT = 4;

	// Configuration registers
	localparam int          APB_ADDR_W       = 3;
	localparam logic        REG_FRAME_RATE   = 1'b0;
	localparam logic        REG_TARGETS      = 1'b1;
	localparam logic [15:0] FRAME_RATE_RESET = 16'd7680;

	typedef enum logic [1:0] {
		ACT_ADVANCE   = 2'd0,
		ACT_INSERT    = 2'd1,
		ACT_SET_FRAME = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_FIRE,
		ST_REPORT,
		ST_SET,
		ST_INSERT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic  load_in;
		logic  mul;
		logic  add;
		logic  set_frame;
		logic  insert;
		logic  pop;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic head_due;
		logic full;
		logic slot_free;
	} status_t;

endpackage

FILE: sv/teq_ctrl.sv
// Sequencer for the timed event queue: decodes each accepted word and
// drives the multiply, add, fire, report, set and insert steps. Uses teq_pkg.
module teq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        action,
	input  logic              targets_attached,
	input  teq_pkg::status_t  status,
	output teq_pkg::cmd_t     cmd
);
	import teq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					unique case (action_t'(action))
						ACT_ADVANCE:   state_nxt = targets_attached ? ST_MUL : ST_REPORT;
						ACT_INSERT:    state_nxt = ST_INSERT;
						ACT_SET_FRAME: state_nxt = ST_SET;
						default:       state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_ADD;
			end
			ST_ADD: begin
				cmd.add   = 1'b1;
				state_nxt = ST_FIRE;
			end
			// Drain due events from the head, then report the position
			ST_FIRE: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					if (status.head_due) begin
						cmd.emit_kind = KIND_FIRED;
						cmd.pop       = 1'b1;
					end else begin
						cmd.emit_kind = KIND_REPORT;
						cmd.emit_last = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end
			end
			ST_REPORT: begin
				if (status.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_REPORT;
					cmd.emit_last = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			ST_SET: begin
				cmd.set_frame = 1'b1;
				state_nxt     = ST_REPORT;
			end
			ST_INSERT: begin
				if (status.full) begin
					if (status.slot_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_REJECT;
						cmd.emit_last = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end else begin
					cmd.insert = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

FILE: sv/teq_datapath.sv
// Datapath of the timed event queue: input latch, rate multiplier, saturating
// position adder, sorted queue row and output register. Uses teq_pkg.
`include "timed_event_queue_core_defines.svh"

module teq_datapath #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = teq_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  teq_pkg::cmd_t                 cmd,
	output teq_pkg::status_t              status,
	input  logic [teq_pkg::ELAPSED_W-1:0] elapsed_time,
	input  logic [ID_BITS-1:0]            event_id,
	input  logic [teq_pkg::FRAME_W-1:0]   event_due,
	input  logic [teq_pkg::WHOLE_W-1:0]   new_frame,
	input  logic [teq_pkg::RATE_W-1:0]    frame_rate,
	output logic                          out_valid,
	input  logic                          out_ready,
	output teq_pkg::kind_t                out_kind,
	output logic [ID_BITS-1:0]            out_id,
	output logic [teq_pkg::FRAME_W-1:0]   out_frame,
	output logic                          out_last
);
	import teq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ELAPSED_W-1:0] elapsed_q;
	logic [ID_BITS-1:0]   id_q;
	logic [FRAME_W-1:0]   due_in_q;
	logic [WHOLE_W-1:0]   new_frame_q;
	logic [PROD_W-1:0]    prod_q;
	logic [FRAME_W-1:0]   pos_q;
	logic [CNT_W-1:0]     count_q;
	logic [FRAME_W-1:0]   due_q [QUEUE_DEPTH];
	logic [ID_BITS-1:0]   qid_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] le;
	logic [QUEUE_DEPTH-1:0] le_prev;
	logic [FRAME_W:0]     sum;
	logic [FRAME_W-1:0]   sum_sat;
	logic                 out_valid_q;
	kind_t                kind_q;
	logic [ID_BITS-1:0]   oid_q;
	logic [FRAME_W-1:0]   oframe_q;
	logic                 olast_q;
	logic                 full;
	logic                 head_due;
	logic                 slot_free;

	// Latch the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			elapsed_q   <= elapsed_time;
			id_q        <= event_id;
			due_in_q    <= event_due;
			new_frame_q <= new_frame;
		end
	end

	// Elapsed time times frame rate, Q12.20
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= elapsed_q * frame_rate;
		end
	end

	// Truncate to Q16.16 and add with saturation
	assign sum     = {1'b0, pos_q} + (FRAME_W + 1)'(prod_q[PROD_W-1:INC_SHIFT]);
	assign sum_sat = sum[FRAME_W] ? '1 : sum[FRAME_W-1:0];

	// Frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.add) begin
			pos_q <= sum_sat;
		end else if (cmd.set_frame) begin
			pos_q <= {new_frame_q, (FRAME_W - WHOLE_W)'(0)};
		end
	end

	// Entries that stay ahead of a new event: valid and due no later
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (count_q > CNT_W'(i)) && (due_q[i] <= due_in_q);
		end
	end
	assign le_prev = {le[QUEUE_DEPTH-2:0], 1'b1};

	// Queue row: keep, take the new event, or shift up on insert; shift down on pop
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!le[0]) begin
				due_q[0] <= due_in_q;
				qid_q[0] <= id_q;
			end
			for (int j = 1; j < QUEUE_DEPTH; j++) begin
				if (!le[j]) begin
					if (le_prev[j]) begin
						due_q[j] <= due_in_q;
						qid_q[j] <= id_q;
					end else begin
						due_q[j] <= due_q[j-1];
						qid_q[j] <= qid_q[j-1];
					end
				end
			end
		end else if (cmd.pop) begin
			for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
				due_q[j] <= due_q[j+1];
				qid_q[j] <= qid_q[j+1];
			end
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_due  = (count_q != '0) && (due_q[0] <= pos_q);
	assign slot_free = !out_valid_q || out_ready;

	assign status.head_due  = head_due;
	assign status.full      = full;
	assign status.slot_free = slot_free;

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.emit_kind;
			oframe_q <= pos_q;
			olast_q  <= cmd.emit_last;
			unique case (cmd.emit_kind)
				KIND_FIRED:  oid_q <= qid_q[0];
				KIND_REJECT: oid_q <= id_q;
				default:     oid_q <= '0;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_id    = oid_q;
	assign out_frame = oframe_q;
	assign out_last  = olast_q;

	`TEQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
	`TEQ_ASSERT_IMP(a_insert_room, cmd.insert, !full, "insert into full queue")
	`TEQ_ASSERT_IMP(a_pop_due, cmd.pop, head_due, "pop without a due head")
	`TEQ_ASSERT_IMP(a_emit_free, cmd.emit, slot_free, "emit overwrites pending word")
	`TEQ_ASSERT_NXT(a_pop_count, cmd.pop, count_q == CNT_W'($past(count_q) - CNT_W'(1)), "pop count")

endmodule

FILE: sv/timed_event_queue_core.sv
// Top level of the timed event queue: stream ports, APB register file,
// controller and datapath. Depends on teq_pkg, teq_ctrl and teq_datapath.
//
//   port group   dir   protocol   carries
//   s_*          in    stream     action (tuser), elapsed/id/due/new_frame (tdata)
//   m_*          out   stream     kind (tuser), fired_id/frame_now (tdata), last
//   p*           in    APB        frame_rate at 0x0, targets_attached at 0x4
//
// Advance with targets: multiply, add, then one output word per cycle from the
// head of the queue while the output slot is free, then a report word. Advance
// without targets and set-frame end in a report word. Insert: the whole queue
// row shifts in one step. Input is taken only between items.
// A stalled m_tready holds the sequencer in its emitting state; one finished
// word waits in the output register while the next input is accepted.
// Reset clears the position, the count and the output valid flag and loads the
// configuration registers with their defaults; queue entries are left as they are.
module timed_event_queue_core #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = teq_pkg::ID_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// elapsed_time[15:0], event_id, event_due[31:0], new_frame[15:0], zero pad
	input  logic [((64 + ID_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// action[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// fired_id, frame_now[31:0], zero pad
	output logic [((32 + ID_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// kind[1:0]
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [teq_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import teq_pkg::*;

	localparam int OUT_W = ((32 + ID_BITS + 7) / 8) * 8;
	localparam int ID_LO  = ELAPSED_W;
	localparam int DUE_LO = ID_LO + ID_BITS;
	localparam int NF_LO  = DUE_LO + FRAME_W;

	logic [RATE_W-1:0]    rate_q;
	logic                 targets_q;
	logic                 cfg_wr;
	logic                 reg_sel;
	cmd_t                 cmd;
	status_t              status;
	kind_t                out_kind;
	logic [ID_BITS-1:0]   out_id;
	logic [FRAME_W-1:0]   out_frame;

	// Register write on the access phase
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= FRAME_RATE_RESET;
			targets_q <= 1'b0;
		end else if (cfg_wr) begin
			if (reg_sel == REG_FRAME_RATE) begin
				rate_q <= pwdata[RATE_W-1:0];
			end else begin
				targets_q <= pwdata[0];
			end
		end
	end

	// Register readback
	assign prdata = (reg_sel == REG_TARGETS) ? {31'd0, targets_q} : {16'd0, rate_q};

	teq_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.action           (s_tuser),
		.targets_attached (targets_q),
		.status           (status),
		.cmd              (cmd)
	);

	teq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.elapsed_time (s_tdata[ELAPSED_W-1:0]),
		.event_id     (s_tdata[ID_LO +: ID_BITS]),
		.event_due    (s_tdata[DUE_LO +: FRAME_W]),
		.new_frame    (s_tdata[NF_LO +: WHOLE_W]),
		.frame_rate   (rate_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (out_kind),
		.out_id       (out_id),
		.out_frame    (out_frame),
		.out_last     (m_tlast)
	);

	// Pack the output word
	assign m_tdata = OUT_W'({out_frame, out_id});
	assign m_tuser = out_kind;

endmodule
